FILE: rtl/dkpq_pkg.sv
package dkpq_pkg;

	localparam int FIELD_W = 16;

	localparam logic [2:0] CMD_INSERT = 3'd0;
	localparam logic [2:0] CMD_RM_MAX = 3'd1;
	localparam logic [2:0] CMD_RM_MIN = 3'd2;
	localparam logic [2:0] CMD_RM_ALL = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

FILE: rtl/dual_key_priority_queue.sv
// Dual-key priority queue: up to CAPACITY entries, each kept twice, once in a
// max-heap on the primary key and once in a min-heap on the secondary key; every
// heap element carries its key, its tag and the position of its twin in the
// other heap. Raise start for one cycle while busy is low to hand in one
// command item; busy stays high until the result item appears for exactly one
// cycle with done high. The receiver cannot stall, so sample the result ports
// in the done cycle. One sift unit (read children or parent, compare, move one
// element) does all heap work, one heap level per read and compare step, so
// the heap depth log2(CAPACITY) bounds the work: an insert sifts up in both
// heaps, a single removal sifts down in one heap and fixes the gap in the
// other, and remove-all repeats a removal once per entry taken out. Clear,
// ignored commands and flagged commands go straight to the output step. Each
// heap sits in a memory with one write port and two registered read ports.
module dual_key_priority_queue #(
	parameter int CAPACITY = 64,
	parameter int KEY_BITS = 16,
	parameter int TAG_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [2:0]                             cmd,
	input  logic [dkpq_pkg::FIELD_W-1:0]           primary_key,
	input  logic [dkpq_pkg::FIELD_W-1:0]           secondary_key,
	input  logic [dkpq_pkg::FIELD_W-1:0]           entry_tag,
	input  logic [dkpq_pkg::FIELD_W-1:0]           threshold,
	output logic                                   done,
	output logic [dkpq_pkg::FIELD_W-1:0]           max_top_tag,
	output logic [dkpq_pkg::FIELD_W-1:0]           max_top_key,
	output logic [dkpq_pkg::FIELD_W-1:0]           min_top_tag,
	output logic [dkpq_pkg::FIELD_W-1:0]           min_top_key,
	output logic [$clog2(CAPACITY+1)-1:0]          entry_count,
	output logic [$clog2(CAPACITY+1)-1:0]          removed_count,
	output logic [1:0]                             status
);
	import dkpq_pkg::*;

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int KTW  = KEY_BITS + TAG_BITS;
	localparam int CMPW = (KEY_BITS > FIELD_W) ? KEY_BITS : FIELD_W;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_RM_RD  = 4'd1;
	localparam logic [3:0] S_RM_FIX = 4'd2;
	localparam logic [3:0] S_SD_RD  = 4'd3;
	localparam logic [3:0] S_SD_EV  = 4'd4;
	localparam logic [3:0] S_SU_RD  = 4'd5;
	localparam logic [3:0] S_SU_EV  = 4'd6;
	localparam logic [3:0] S_WR_E   = 4'd7;
	localparam logic [3:0] S_LD_RD  = 4'd8;
	localparam logic [3:0] S_LD_EV  = 4'd9;
	localparam logic [3:0] S_OUT_RD = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;

	// strict order of heap g: max-heap for g = 0, min-heap for g = 1
	function automatic logic better(input logic g, input logic [KEY_BITS-1:0] a,
			input logic [KEY_BITS-1:0] b);
		return g ? (a < b) : (a > b);
	endfunction

	function automatic logic [KEY_BITS-1:0] key_of(input logic [KTW-1:0] kt);
		return kt[KTW-1:TAG_BITS];
	endfunction

	logic [3:0]          state_q;
	logic [2:0]          cmd_q;
	logic [FIELD_W-1:0]  thr_q;
	logic [KEY_BITS-1:0] skey_q;
	logic [AW-1:0]       ins_pos_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       removed_q;
	logic [1:0]          status_q;
	logic                h_q;       // heap whose top is being removed
	logic                g_q;       // heap the sift unit works on
	logic                ph_q;      // second sift of the command
	logic                updn_q;    // sift down when sift up did not move
	logic                moved_q;
	logic                jv_q;
	logic [AW-1:0]       j_q;       // gap in the other heap
	logic [AW-1:0]       pos_q;
	logic [KTW-1:0]      e_kt_q;    // element being sifted
	logic [AW-1:0]       e_tw_q;

	logic                done_q;
	logic [FIELD_W-1:0]  max_tag_q, max_key_q, min_tag_q, min_key_q;

	// heap memories
	logic [KTW-1:0] kt_mem [2][CAPACITY];
	logic [AW-1:0]  tw_mem [2][CAPACITY];
	logic [1:0]     kt_we, tw_we;
	logic [AW-1:0]  kt_wa [2];
	logic [AW-1:0]  tw_wa [2];
	logic [KTW-1:0] kt_wd [2];
	logic [AW-1:0]  tw_wd [2];
	logic [AW-1:0]  ra0 [2];
	logic [AW-1:0]  ra1 [2];
	logic [KTW-1:0] rkt0_q [2];
	logic [KTW-1:0] rkt1_q [2];
	logic [AW-1:0]  rtw0_q [2];
	logic [AW-1:0]  rtw1_q [2];

	always_ff @(posedge clk) begin
		for (int gi = 0; gi < 2; gi++) begin
			if (kt_we[gi]) kt_mem[gi][kt_wa[gi]] <= kt_wd[gi];
			if (tw_we[gi]) tw_mem[gi][tw_wa[gi]] <= tw_wd[gi];
			rkt0_q[gi] <= kt_mem[gi][ra0[gi]];
			rkt1_q[gi] <= kt_mem[gi][ra1[gi]];
			rtw0_q[gi] <= tw_mem[gi][ra0[gi]];
			rtw1_q[gi] <= tw_mem[gi][ra1[gi]];
		end
	end

	// index arithmetic of the sift unit
	logic [AW-1:0]   last;
	logic [AW+1:0]   n_x, c1_x, c2_x;
	logic            c1_in, c2_in;
	logic [AW-1:0]   c1_a, c2_a, par;

	assign last  = AW'(cnt_q - CW'(1));
	assign n_x   = (AW+2)'(cnt_q);
	assign c1_x  = {1'b0, pos_q, 1'b1};
	assign c2_x  = c1_x + (AW+2)'(1);
	assign c1_in = c1_x < n_x;
	assign c2_in = c2_x < n_x;
	assign c1_a  = c1_x[AW-1:0];
	assign c2_a  = c2_in ? c2_x[AW-1:0] : c1_a;
	assign par   = (pos_q - AW'(1)) >> 1;

	// sift-down choice: right child only when strictly better
	logic           sel_r, sd_swap, su_swap, thr_stop;
	logic [KTW-1:0] ch_kt;
	logic [AW-1:0]  ch_tw, ch_idx;

	assign sel_r   = c2_in && better(g_q, key_of(rkt1_q[g_q]), key_of(rkt0_q[g_q]));
	assign ch_kt   = sel_r ? rkt1_q[g_q] : rkt0_q[g_q];
	assign ch_tw   = sel_r ? rtw1_q[g_q] : rtw0_q[g_q];
	assign ch_idx  = sel_r ? c2_a : c1_a;
	assign sd_swap = better(g_q, key_of(ch_kt), key_of(e_kt_q));
	assign su_swap = better(g_q, key_of(e_kt_q), key_of(rkt0_q[g_q]));

	// removal: victim at top of heap h, last elements of both heaps
	logic [AW-1:0] v_tw, m_tw;
	assign v_tw     = rtw0_q[h_q];
	assign m_tw     = rtw0_q[~h_q];
	assign thr_stop = (cmd_q == CMD_RM_ALL) &&
		(CMPW'(key_of(rkt0_q[h_q])) < CMPW'(thr_q));

	always_comb begin
		kt_we = '0;
		tw_we = '0;
		for (int gi = 0; gi < 2; gi++) begin
			kt_wa[gi] = '0;
			tw_wa[gi] = '0;
			kt_wd[gi] = '0;
			tw_wd[gi] = '0;
			ra0[gi]   = '0;
			ra1[gi]   = '0;
		end
		unique case (state_q)
			S_RM_RD: begin
				ra0[h_q]  = '0;
				ra1[h_q]  = last;
				ra0[~h_q] = last;
				ra1[~h_q] = last;
			end
			S_RM_FIX: begin
				// fill the gap in the other heap with its last element
				if (!thr_stop && v_tw != last) begin
					kt_we[~h_q] = 1'b1;
					kt_wa[~h_q] = v_tw;
					kt_wd[~h_q] = rkt0_q[~h_q];
					tw_we[~h_q] = 1'b1;
					tw_wa[~h_q] = v_tw;
					tw_wd[~h_q] = m_tw;
					if (m_tw != last) begin
						tw_we[h_q] = 1'b1;
						tw_wa[h_q] = m_tw;
						tw_wd[h_q] = v_tw;
					end
				end
			end
			S_SD_RD: begin
				ra0[g_q] = c1_a;
				ra1[g_q] = c2_a;
			end
			S_SD_EV: begin
				if (sd_swap) begin
					kt_we[g_q]  = 1'b1;
					kt_wa[g_q]  = pos_q;
					kt_wd[g_q]  = ch_kt;
					tw_we[g_q]  = 1'b1;
					tw_wa[g_q]  = pos_q;
					tw_wd[g_q]  = ch_tw;
					tw_we[~g_q] = 1'b1;
					tw_wa[~g_q] = ch_tw;
					tw_wd[~g_q] = pos_q;
				end
			end
			S_SU_RD: ra0[g_q] = par;
			S_SU_EV: begin
				if (su_swap) begin
					kt_we[g_q]  = 1'b1;
					kt_wa[g_q]  = pos_q;
					kt_wd[g_q]  = rkt0_q[g_q];
					tw_we[g_q]  = 1'b1;
					tw_wa[g_q]  = pos_q;
					tw_wd[g_q]  = rtw0_q[g_q];
					tw_we[~g_q] = 1'b1;
					tw_wa[~g_q] = rtw0_q[g_q];
					tw_wd[~g_q] = pos_q;
				end
			end
			S_WR_E: begin
				kt_we[g_q]  = 1'b1;
				kt_wa[g_q]  = pos_q;
				kt_wd[g_q]  = e_kt_q;
				tw_we[g_q]  = 1'b1;
				tw_wa[g_q]  = pos_q;
				tw_wd[g_q]  = e_tw_q;
				tw_we[~g_q] = 1'b1;
				tw_wa[~g_q] = e_tw_q;
				tw_wd[~g_q] = pos_q;
			end
			S_LD_RD: ra0[g_q] = pos_q;
			S_OUT_RD: begin
				ra0[0] = '0;
				ra0[1] = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			done_q    <= 1'b0;
			removed_q <= '0;
			status_q  <= ST_OK;
			max_tag_q <= '0;
			max_key_q <= '0;
			min_tag_q <= '0;
			min_key_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q     <= cmd;
						thr_q     <= threshold;
						removed_q <= '0;
						status_q  <= ST_OK;
						moved_q   <= 1'b0;
						ph_q      <= 1'b0;
						updn_q    <= 1'b0;
						g_q       <= 1'b0;
						unique case (cmd)
							CMD_INSERT: begin
								if (cnt_q == CW'(CAPACITY)) begin
									status_q <= ST_FULL;
									state_q  <= S_OUT_RD;
								end else begin
									// enter at the bottom of the max-heap, sift up
									e_kt_q    <= {KEY_BITS'(primary_key), TAG_BITS'(entry_tag)};
									skey_q    <= KEY_BITS'(secondary_key);
									e_tw_q    <= AW'(cnt_q);
									pos_q     <= AW'(cnt_q);
									ins_pos_q <= AW'(cnt_q);
									cnt_q     <= cnt_q + CW'(1);
									state_q   <= S_SU_RD;
								end
							end
							CMD_RM_MAX, CMD_RM_MIN, CMD_RM_ALL: begin
								if (cnt_q == '0) begin
									status_q <= ST_EMPTY;
									state_q  <= S_OUT_RD;
								end else begin
									h_q     <= (cmd == CMD_RM_MIN);
									state_q <= S_RM_RD;
								end
							end
							CMD_CLEAR: begin
								removed_q <= cnt_q;
								cnt_q     <= '0;
								state_q   <= S_OUT_RD;
							end
							default: state_q <= S_OUT_RD;
						endcase
					end
				end
				S_RM_RD: state_q <= S_RM_FIX;
				S_RM_FIX: begin
					if (thr_stop) begin
						state_q <= S_OUT_RD;
					end else begin
						// last element of heap h takes the root and sifts down
						e_kt_q    <= rkt1_q[h_q];
						e_tw_q    <= (v_tw != last && m_tw == last) ? v_tw : rtw1_q[h_q];
						pos_q     <= '0;
						g_q       <= h_q;
						cnt_q     <= cnt_q - CW'(1);
						removed_q <= removed_q + CW'(1);
						ph_q      <= 1'b0;
						updn_q    <= 1'b0;
						moved_q   <= 1'b0;
						jv_q      <= (v_tw != last);
						j_q       <= v_tw;
						state_q   <= S_SD_RD;
					end
				end
				S_SD_RD: state_q <= c1_in ? S_SD_EV : S_WR_E;
				S_SD_EV: begin
					if (sd_swap) begin
						pos_q   <= ch_idx;
						state_q <= S_SD_RD;
					end else begin
						state_q <= S_WR_E;
					end
				end
				S_SU_RD: begin
					if (pos_q == '0)
						state_q <= (updn_q && !moved_q) ? S_SD_RD : S_WR_E;
					else
						state_q <= S_SU_EV;
				end
				S_SU_EV: begin
					if (su_swap) begin
						pos_q   <= par;
						moved_q <= 1'b1;
						state_q <= S_SU_RD;
					end else begin
						state_q <= (updn_q && !moved_q) ? S_SD_RD : S_WR_E;
					end
				end
				S_WR_E: begin
					if (cmd_q == CMD_INSERT) begin
						if (!ph_q) begin
							// now the min-heap, twin points at the final max-heap spot
							ph_q    <= 1'b1;
							g_q     <= 1'b1;
							e_kt_q  <= {skey_q, e_kt_q[TAG_BITS-1:0]};
							e_tw_q  <= pos_q;
							pos_q   <= ins_pos_q;
							moved_q <= 1'b0;
							state_q <= S_SU_RD;
						end else begin
							state_q <= S_OUT_RD;
						end
					end else if (!ph_q && jv_q) begin
						// element moved into the gap of the other heap: up, then down
						ph_q    <= 1'b1;
						g_q     <= ~g_q;
						pos_q   <= j_q;
						updn_q  <= 1'b1;
						moved_q <= 1'b0;
						state_q <= S_LD_RD;
					end else if (cmd_q == CMD_RM_ALL && cnt_q != '0) begin
						state_q <= S_RM_RD;
					end else begin
						state_q <= S_OUT_RD;
					end
				end
				S_LD_RD: state_q <= S_LD_EV;
				S_LD_EV: begin
					e_kt_q  <= rkt0_q[g_q];
					e_tw_q  <= rtw0_q[g_q];
					state_q <= S_SU_RD;
				end
				S_OUT_RD: state_q <= S_OUT;
				S_OUT: begin
					if (cnt_q != '0) begin
						max_tag_q <= FIELD_W'(rkt0_q[0][TAG_BITS-1:0]);
						max_key_q <= FIELD_W'(key_of(rkt0_q[0]));
						min_tag_q <= FIELD_W'(rkt0_q[1][TAG_BITS-1:0]);
						min_key_q <= FIELD_W'(key_of(rkt0_q[1]));
					end else begin
						max_tag_q <= '0;
						max_key_q <= '0;
						min_tag_q <= '0;
						min_key_q <= '0;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign max_top_tag   = max_tag_q;
	assign max_top_key   = max_key_q;
	assign min_top_tag   = min_tag_q;
	assign min_top_key   = min_key_q;
	assign entry_count   = cnt_q;
	assign removed_count = removed_q;
	assign status        = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> removed_count == '0 && entry_count == CW'(CAPACITY))
		else $error("dropped insert changed the store");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EMPTY |-> entry_count == '0 && removed_count == '0)
		else $error("empty flag on a non-empty store");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == S_OUT)
		else $error("result strobe outside the output step");

endmodule
